/* sv/longest_distinct_substring_defines.svh */
// Assertion macros for the longest distinct substring block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef LONGEST_DISTINCT_SUBSTRING_DEFINES_SVH
`define LONGEST_DISTINCT_SUBSTRING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lds_pkg.sv */
// Shared constants for the longest distinct substring block.
// No dependencies.
`default_nettype none

package lds_pkg;
	localparam int CHAR_W = 8;
	localparam int ALPHA = 256;
	localparam int LEN_W = 16;
	localparam logic [LEN_W-1:0] LEN_SAT = 16'hFFFF;
endpackage

`default_nettype wire

/* sv/lds_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the old data.
`default_nettype none

module lds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/longest_distinct_substring.sv */
// A result passes from the stage-one registers to the output registers after its last byte.
// Throughput: one byte per cycle while in_stall is low; set by the single read and write of the
// last-position table per byte, whose write goes at transfer time.
// in_stall rises only while a finished result waits in a stalled output.
// Reset clears valid bits, counters and the output valid flag; table contents stay undefined.
// Depends on lds_pkg, lds_ram and longest_distinct_substring_defines.svh.
`default_nettype none
`include "longest_distinct_substring_defines.svh"

module longest_distinct_substring #(
	parameter longint unsigned MAX_STRING_LEN = 65535
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lds_pkg::CHAR_W-1:0]  char_byte,
	input  wire logic                        end_of_string,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [lds_pkg::LEN_W-1:0]   longest_len,
	output logic                             overflowed
);

	localparam int POS_W = $clog2(MAX_STRING_LEN);
	localparam int CNT_W = $clog2(MAX_STRING_LEN + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STRING_LEN);

	logic                      accept;
	logic                      active0;
	logic [lds_pkg::ALPHA-1:0] valid_q;
	logic [CNT_W-1:0]          cur_pos_q;
	logic                      ovf_q;

	logic                      v_s1;
	logic                      end_s1;
	logic                      act_s1;
	logic                      seen_s1;
	logic                      ovf_s1;
	logic [POS_W-1:0]          pos_s1;
	logic [POS_W-1:0]          rd_pos;

	logic [POS_W-1:0]          ws_q;
	logic [CNT_W-1:0]          best_q;
	logic [POS_W-1:0]          ws_nxt;
	logic [CNT_W-1:0]          len;
	logic [CNT_W-1:0]          best_nxt;
	logic [63:0]               best_ext;
	logic                      hold;
	logic                      fire;

	logic                      out_valid_q;
	logic [lds_pkg::LEN_W-1:0] longest_len_q;
	logic                      overflowed_q;

	assign active0 = (cur_pos_q != MAX_CNT);
	assign hold = v_s1 & end_s1 & out_valid_q & out_stall;
	assign fire = v_s1 & ~hold;
	assign in_stall = hold;
	assign accept = in_valid & ~in_stall;

	lds_ram #(
		.WIDTH(POS_W),
		.DEPTH(lds_pkg::ALPHA)
	) u_pos_ram (
		.clk  (clk),
		.we   (accept & active0),
		.waddr(char_byte),
		.wdata(cur_pos_q[POS_W-1:0]),
		.re   (accept),
		.raddr(char_byte),
		.rdata(rd_pos)
	);

	// Position bookkeeping at transfer time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cur_pos_q <= '0;
			ovf_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (end_of_string) begin
					valid_q <= '0;
					cur_pos_q <= '0;
					ovf_q <= 1'b0;
				end else if (active0) begin
					valid_q[char_byte] <= 1'b1;
					cur_pos_q <= cur_pos_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			end_s1 <= end_of_string;
			act_s1 <= active0;
			seen_s1 <= valid_q[char_byte];
			ovf_s1 <= ovf_q | ~active0;
			pos_s1 <= cur_pos_q[POS_W-1:0];
		end
	end

	always_comb begin
		ws_nxt = ws_q;
		if (seen_s1 && (rd_pos >= ws_q)) begin
			ws_nxt = rd_pos + POS_W'(1);
		end
		len = CNT_W'(pos_s1) - CNT_W'(ws_nxt) + CNT_W'(1);
		best_nxt = best_q;
		if (act_s1 && (len > best_q)) begin
			best_nxt = len;
		end
		best_ext = 64'(best_nxt);
	end

	// Advance the window; drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= '0;
			best_q <= '0;
		end else if (fire) begin
			if (end_s1) begin
				ws_q <= '0;
				best_q <= '0;
			end else begin
				if (act_s1) begin
					ws_q <= ws_nxt;
				end
				best_q <= best_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && end_s1) begin
			longest_len_q <= (best_ext > 64'(lds_pkg::LEN_SAT)) ? lds_pkg::LEN_SAT
				: best_ext[lds_pkg::LEN_W-1:0];
			overflowed_q <= ovf_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign longest_len = longest_len_q;
	assign overflowed = overflowed_q;

	`LDS_ASSERT_NEXT(a_clear_after_end, fire && end_s1,
		(best_q == '0) && (ws_q == '0), "window state not cleared after last byte")
	`LDS_ASSERT_NOW(a_ws_within_pos, fire && act_s1, ws_nxt <= pos_s1,
		"window start passed current position")
	`LDS_ASSERT_NEXT(a_result_nonzero, fire && end_s1, longest_len != '0,
		"result length is zero")

endmodule

`default_nettype wire
